>>> rtl/hsat_pkg.sv
// Package for the hazard summed-area table unit.
// Holds the shared widths, codes, queue item type and back-end states.
// No dependencies.
package hsat_pkg;

    localparam int SZW  = 9;   // map size, raster position and row run width
    localparam int CW   = 8;   // cost byte and rectangle bound width
    localparam int CNTW = 17;  // table entry and hazard count width
    localparam int IDXW = 2;   // configuration register index width

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PW    = $clog2(FIFO_DEPTH);

    localparam logic [IDXW-1:0] REG_MAP_WIDTH        = 2'd0;
    localparam logic [IDXW-1:0] REG_MAP_HEIGHT       = 2'd1;
    localparam logic [IDXW-1:0] REG_UNKNOWN_CODE     = 2'd2;
    localparam logic [IDXW-1:0] REG_LETHAL_THRESHOLD = 2'd3;

    typedef enum logic [0:0] {
        OP_CELL  = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_READY = 2'd1,
        ST_BAD_RECT  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CELL,
        S_Q_RD2,
        S_Q_SUM
    } t_back_state;

    typedef struct packed {
        logic [SZW-1:0] used_w;
        logic [SZW-1:0] used_h;
        logic [CW-1:0]  unknown_code;
        logic [CW-1:0]  lethal_threshold;
    } t_cfg;

    typedef struct packed {
        t_opcode       kind;
        logic          new_map;
        logic          hazard;
        logic          bad_rect;
        logic [CW-1:0] min_x;
        logic [CW-1:0] min_y;
        logic [CW-1:0] max_x;
        logic [CW-1:0] max_y;
    } t_item;

endpackage

>>> rtl/hsat_front.sv
// Front end of the hazard summed-area table unit: accepts a transaction and
// classifies it into a queue item. Depends on hsat_pkg.
module hsat_front import hsat_pkg::*; (
    input  logic          i_start,
    input  logic          i_full,
    input  t_cfg          i_cfg,
    input  logic          i_opcode,
    input  logic          i_new_map,
    input  logic [CW-1:0] i_cell_cost,
    input  logic [CW-1:0] i_rect_min_x,
    input  logic [CW-1:0] i_rect_min_y,
    input  logic [CW-1:0] i_rect_max_x,
    input  logic [CW-1:0] i_rect_max_y,
    output logic          o_push,
    output t_item         o_item
);

    always_comb begin
        o_push          = i_start && !i_full;
        o_item.kind     = t_opcode'(i_opcode);
        o_item.new_map  = i_new_map;
        o_item.hazard   = (i_cell_cost == i_cfg.unknown_code)
                       || (i_cell_cost >= i_cfg.lethal_threshold);
        // Checked here; the user must not change the size while items are queued.
        o_item.bad_rect = (i_rect_min_x > i_rect_max_x)
                       || (i_rect_min_y > i_rect_max_y)
                       || ({1'b0, i_rect_max_x} >= i_cfg.used_w)
                       || ({1'b0, i_rect_max_y} >= i_cfg.used_h);
        o_item.min_x    = i_rect_min_x;
        o_item.min_y    = i_rect_min_y;
        o_item.max_x    = i_rect_max_x;
        o_item.max_y    = i_rect_max_y;
    end

endmodule

>>> rtl/hsat_fifo.sv
// Short item queue between the front and back ends.
// Depends on hsat_pkg for the item type and depth.
module hsat_fifo import hsat_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_valid,
    output logic  o_full
);

    t_item               r_mem [FIFO_DEPTH];
    logic [FIFO_PW-1:0]  r_wr_ptr;
    logic [FIFO_PW-1:0]  r_rd_ptr;
    logic [FIFO_PW:0]    r_count;
    logic                w_do_pop;

    assign o_item   = r_mem[r_rd_ptr];
    assign o_valid  = (r_count != '0);
    assign o_full   = (r_count == (FIFO_PW+1)'(FIFO_DEPTH));
    assign w_do_pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && w_do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

>>> rtl/hsat_back.sv
// Back end of the hazard summed-area table unit: raster state, the
// integral-image memory and the query sequencer. Depends on hsat_pkg.
module hsat_back import hsat_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cfg            i_cfg,
    input  logic            i_restart,
    input  t_item           i_item,
    input  logic            i_item_valid,
    output logic            o_pop,
    output logic            o_table_ready,
    output logic            o_result_valid,
    output logic [1:0]      o_query_status,
    output logic [CNTW-1:0] o_hazard_count
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = AW + SZW + 1;

    function automatic logic [AW-1:0] addr_of(input logic [SZW-1:0] row,
                                               input logic [SZW-1:0] col);
        logic [PW-1:0] full;
        full = PW'(row) * PW'(MAX_WIDTH) + PW'(col);
        return full[AW-1:0];
    endfunction

    logic [CNTW-1:0] r_table [DEPTH];

    t_back_state     r_state;
    t_back_state     n_state;
    logic [SZW-1:0]  r_row;
    logic [SZW-1:0]  r_col;
    logic [SZW-1:0]  r_run;
    logic            r_ready;
    t_item           r_item;
    logic [CNTW-1:0] r_rd_a;
    logic [CNTW-1:0] r_rd_b;
    logic [CNTW-1:0] r_part;
    logic            r_out_valid;
    t_status         r_out_status;
    logic [CNTW-1:0] r_out_count;

    logic [SZW-1:0]  w_eff_row;
    logic [SZW-1:0]  w_eff_col;
    logic            w_eff_ready;
    logic            w_cell_go;
    logic            w_q_reject;
    t_status         w_q_status;
    logic [SZW-1:0]  w_run_next;
    logic [SZW-1:0]  w_col_next;
    logic [SZW-1:0]  w_row_next;
    logic [AW-1:0]   w_rd_addr_a;
    logic [AW-1:0]   w_rd_addr_b;
    logic            w_we;
    logic [AW-1:0]   w_wr_addr;
    logic [CNTW-1:0] w_wr_data;
    logic [CNTW-1:0] w_above;

    // A new map restarts the raster before its own cell is placed.
    assign w_eff_row   = i_item.new_map ? '0 : r_row;
    assign w_eff_col   = i_item.new_map ? '0 : r_col;
    assign w_eff_ready = i_item.new_map ? 1'b0 : r_ready;
    assign w_cell_go   = !((i_cfg.used_w == '0) || (i_cfg.used_h == '0) || w_eff_ready
                        || (w_eff_row >= i_cfg.used_h) || (w_eff_col >= i_cfg.used_w));

    assign w_q_reject  = !r_ready || (i_cfg.used_w == '0) || (i_cfg.used_h == '0)
                      || i_item.bad_rect;
    assign w_q_status  = (!r_ready || (i_cfg.used_w == '0) || (i_cfg.used_h == '0))
                       ? ST_NOT_READY : ST_BAD_RECT;

    assign w_run_next  = r_run + SZW'(r_item.hazard);
    assign w_col_next  = r_col + 1'b1;
    assign w_row_next  = r_row + 1'b1;
    assign w_above     = (r_row != '0) ? r_rd_a : '0;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    if (i_item.kind == OP_CELL) begin
                        if (w_cell_go) begin
                            n_state = S_CELL;
                        end
                    end else if (!w_q_reject) begin
                        n_state = S_Q_RD2;
                    end
                end
            end
            S_CELL:  n_state = S_IDLE;
            S_Q_RD2: n_state = S_Q_SUM;
            S_Q_SUM: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Corner reads: the far corner and the left corner first, the two upper
    // corners in S_Q_RD2. Border corners are masked when the sum is formed.
    always_comb begin
        o_pop       = 1'b0;
        w_we        = 1'b0;
        w_rd_addr_a = '0;
        w_rd_addr_b = '0;
        w_wr_addr   = addr_of(r_row, r_col);
        w_wr_data   = w_above + CNTW'(w_run_next);
        case (r_state)
            S_IDLE: begin
                o_pop = i_item_valid;
                if (i_item.kind == OP_CELL) begin
                    w_rd_addr_a = addr_of(w_eff_row - 1'b1, w_eff_col);
                end else begin
                    w_rd_addr_a = addr_of({1'b0, i_item.max_y}, {1'b0, i_item.max_x});
                    w_rd_addr_b = addr_of({1'b0, i_item.max_y},
                                          {1'b0, i_item.min_x} - 1'b1);
                end
            end
            S_CELL: begin
                w_we = 1'b1;
            end
            S_Q_RD2: begin
                w_rd_addr_a = addr_of({1'b0, r_item.min_y} - 1'b1, {1'b0, r_item.max_x});
                w_rd_addr_b = addr_of({1'b0, r_item.min_y} - 1'b1,
                                      {1'b0, r_item.min_x} - 1'b1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_table[w_wr_addr] <= w_wr_data;
        end
        r_rd_a <= r_table[w_rd_addr_a];
        r_rd_b <= r_table[w_rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_run       <= '0;
            r_ready     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= 1'b0;
            if (i_restart) begin
                r_row   <= '0;
                r_col   <= '0;
                r_run   <= '0;
                r_ready <= 1'b0;
            end else begin
                case (r_state)
                    S_IDLE: begin
                        if (i_item_valid) begin
                            if (i_item.kind == OP_CELL) begin
                                if (i_item.new_map) begin
                                    r_row   <= '0;
                                    r_col   <= '0;
                                    r_run   <= '0;
                                    r_ready <= 1'b0;
                                end
                            end else if (w_q_reject) begin
                                r_out_valid <= 1'b1;
                            end
                        end
                    end
                    S_CELL: begin
                        if (w_col_next >= i_cfg.used_w) begin
                            r_col <= '0;
                            r_run <= '0;
                            r_row <= w_row_next;
                            if (w_row_next >= i_cfg.used_h) begin
                                r_ready <= 1'b1;
                            end
                        end else begin
                            r_col <= w_col_next;
                            r_run <= w_run_next;
                        end
                    end
                    S_Q_SUM: begin
                        r_out_valid <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    r_item       <= i_item;
                    r_out_status <= w_q_status;
                    r_out_count  <= '0;
                end
            end
            S_Q_RD2: begin
                r_part <= r_rd_a - ((r_item.min_x != '0) ? r_rd_b : '0);
            end
            S_Q_SUM: begin
                r_out_status <= ST_OK;
                r_out_count  <= r_part
                              - ((r_item.min_y != '0) ? r_rd_a : '0)
                              + (((r_item.min_x != '0) && (r_item.min_y != '0))
                                 ? r_rd_b : '0);
            end
            default: begin
            end
        endcase
    end

    assign o_table_ready  = r_ready;
    assign o_result_valid = r_out_valid;
    assign o_query_status = r_out_status;
    assign o_hazard_count = r_out_count;

endmodule

>>> rtl/hazard_summed_area_table_unit.sv
// Top level of the hazard summed-area table unit: configuration registers,
// front end, item queue and back end. Depends on hsat_pkg, hsat_front,
// hsat_fifo and hsat_back.
//
//  Channel   Direction  Handshake                  Payload
//  command   in         start && !busy             i_opcode, i_new_map, i_cell_cost,
//                                                  i_rect_min_x/y, i_rect_max_x/y
//  config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//  result    out        o_result_valid, one cycle  o_query_status, o_hazard_count
//
// A transaction enters the queue, which holds four, at the edge that accepts it; busy is
// high only while the queue is full, and the result receiver never stalls the unit.
// The back end reads the cell above a placed cell in S_IDLE and writes it in S_CELL; an
// ignored cell or a rejected query is settled in S_IDLE, and a good query goes on through
// S_Q_RD2 and S_Q_SUM, set by the table's two read ports and one write port. The back end
// takes the next item from the queue only in S_IDLE. Reset is synchronous and active low;
// the table is not cleared, as nothing is read before the map is rewritten.
module hazard_summed_area_table_unit import hsat_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  logic            i_cfg_we,
    input  logic [IDXW-1:0] i_cfg_index,
    input  logic [SZW-1:0]  i_cfg_data,
    input  logic            i_opcode,
    input  logic            i_new_map,
    input  logic [CW-1:0]   i_cell_cost,
    input  logic [CW-1:0]   i_rect_min_x,
    input  logic [CW-1:0]   i_rect_min_y,
    input  logic [CW-1:0]   i_rect_max_x,
    input  logic [CW-1:0]   i_rect_max_y,
    output logic            o_result_valid,
    output logic [1:0]      o_query_status,
    output logic [CNTW-1:0] o_hazard_count
);

    logic [SZW-1:0] r_map_width;
    logic [SZW-1:0] r_map_height;
    logic [CW-1:0]  r_unknown_code;
    logic [CW-1:0]  r_lethal_threshold;

    t_cfg  w_cfg;
    logic  w_full;
    logic  w_push;
    t_item w_push_item;
    t_item w_head_item;
    logic  w_head_valid;
    logic  w_pop;
    logic  w_table_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width        <= SZW'(256);
            r_map_height       <= SZW'(256);
            r_unknown_code     <= CW'(255);
            r_lethal_threshold <= CW'(254);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_MAP_WIDTH:        r_map_width        <= i_cfg_data;
                REG_MAP_HEIGHT:       r_map_height       <= i_cfg_data;
                REG_UNKNOWN_CODE:     r_unknown_code     <= i_cfg_data[CW-1:0];
                REG_LETHAL_THRESHOLD: r_lethal_threshold <= i_cfg_data[CW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Sizes beyond the table saturate at its dimensions.
    always_comb begin
        w_cfg.used_w = (int'(r_map_width) > MAX_WIDTH) ? SZW'(MAX_WIDTH) : r_map_width;
        w_cfg.used_h = (int'(r_map_height) > MAX_HEIGHT) ? SZW'(MAX_HEIGHT) : r_map_height;
        w_cfg.unknown_code     = r_unknown_code;
        w_cfg.lethal_threshold = r_lethal_threshold;
    end

    assign busy = w_full;

    hsat_front u_front (
        .i_start      (start),
        .i_full       (w_full),
        .i_cfg        (w_cfg),
        .i_opcode     (i_opcode),
        .i_new_map    (i_new_map),
        .i_cell_cost  (i_cell_cost),
        .i_rect_min_x (i_rect_min_x),
        .i_rect_min_y (i_rect_min_y),
        .i_rect_max_x (i_rect_max_x),
        .i_rect_max_y (i_rect_max_y),
        .o_push       (w_push),
        .o_item       (w_push_item)
    );

    hsat_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_item  (w_head_item),
        .o_valid (w_head_valid),
        .o_full  (w_full)
    );

    hsat_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_restart      (i_cfg_we),
        .i_item         (w_head_item),
        .i_item_valid   (w_head_valid),
        .o_pop          (w_pop),
        .o_table_ready  (w_table_ready),
        .o_result_valid (o_result_valid),
        .o_query_status (o_query_status),
        .o_hazard_count (o_hazard_count)
    );

    // A rejected query never reports a count.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_query_status != ST_OK)) |-> (o_hazard_count == '0))
        else $error("rejected query reported a nonzero hazard count");

    a_cfg_clears_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !w_table_ready)
        else $error("configuration write did not clear the ready flag");

    a_ok_needs_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_query_status == ST_OK)) |-> w_table_ready)
        else $error("query answered ok while the table was not complete");

endmodule

>>> sim/tb_hazard_summed_area_table_unit.sv
// Self-checking testbench for hazard_summed_area_table_unit: directed rows, then random maps
// and rectangle queries, each result compared with an in-bench integral-image predictor.
// Depends on hsat_pkg and the RTL of the unit; reads no files.
module tb_hazard_summed_area_table_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import hsat_pkg::*;

    localparam int unsigned MAP_MAX      = 256;
    localparam int unsigned DRAIN_CYCLES = 32;
    localparam int unsigned IDLE_LIMIT   = 4000;
    localparam int unsigned RANDOM_ITEMS = 1200;
    localparam int unsigned PRINT_CAP    = 100;

    typedef struct {
        t_opcode      op;
        bit           nm;
        bit [CW-1:0]  cost;
        bit [CW-1:0]  lx;
        bit [CW-1:0]  ly;
        bit [CW-1:0]  ux;
        bit [CW-1:0]  uy;
    } t_cmd;

    typedef struct {
        t_status        st;
        bit [CNTW-1:0]  cnt;
    } t_answer;

    typedef enum bit {ROW_CMD, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind        kind;
        t_cmd             cmd;
        bit [IDXW-1:0]    reg_idx;
        bit [SZW-1:0]     reg_val;
        bit               typed;
        t_status          want;
    } t_row;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start = 1'b0;
    logic            busy;
    logic            i_cfg_we = 1'b0;
    logic [IDXW-1:0] i_cfg_index = '0;
    logic [SZW-1:0]  i_cfg_data = '0;
    logic            i_opcode = 1'b0;
    logic            i_new_map = 1'b0;
    logic [CW-1:0]   i_cell_cost = '0;
    logic [CW-1:0]   i_rect_min_x = '0;
    logic [CW-1:0]   i_rect_min_y = '0;
    logic [CW-1:0]   i_rect_max_x = '0;
    logic [CW-1:0]   i_rect_max_y = '0;
    logic            o_result_valid;
    logic [1:0]      o_query_status;
    logic [CNTW-1:0] o_hazard_count;

    // Predictor state: integral image of hazard counts, raster position and registers.
    bit [CNTW-1:0]   hazard_prefix [MAP_MAX*MAP_MAX];
    int unsigned     row_run = 0;
    int unsigned     ras_col = 0;
    int unsigned     ras_row = 0;
    bit              map_ready = 1'b0;
    bit [SZW-1:0]    cfg_w = 256;
    bit [SZW-1:0]    cfg_h = 256;
    bit [CW-1:0]     cfg_unk = 255;
    bit [CW-1:0]     cfg_lethal = 254;

    t_answer         answers_due [$];
    t_row            plan [$];
    bit              gaps_off = 1'b0;
    int unsigned     err_count = 0;
    int unsigned     live_items = 0;
    int unsigned     queries_sent = 0;
    int unsigned     ok_answers = 0;
    int unsigned     maps_done = 0;
    int unsigned     reg_writes = 0;
    int unsigned     quiet_cycles = 0;

    hazard_summed_area_table_unit dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic int unsigned span(bit [SZW-1:0] v);
        return (v > MAP_MAX) ? MAP_MAX : int'(v);
    endfunction

    function automatic void restart_raster();
        row_run = 0;
        ras_col = 0;
        ras_row = 0;
        map_ready = 1'b0;
    endfunction

    // Border row and border column of the integral image read as zero.
    function automatic bit [CNTW-1:0] integral_at(int unsigned x, int unsigned y);
        if (x == 0 || y == 0)
            return '0;
        return hazard_prefix[(y - 1) * MAP_MAX + x - 1];
    endfunction

    // Returns 1 when the cell lands in the table, 0 when the unit drops it.
    function automatic bit integrate_cell(bit nm, bit [CW-1:0] cost);
        int unsigned   w;
        int unsigned   h;
        bit [CNTW-1:0] above;
        w = span(cfg_w);
        h = span(cfg_h);
        if (nm)
            restart_raster();
        if (w == 0 || h == 0 || map_ready || ras_row >= h || ras_col >= w)
            return 1'b0;
        if (cost == cfg_unk || cost >= cfg_lethal)
            row_run++;
        above = (ras_row > 0) ? hazard_prefix[(ras_row - 1) * MAP_MAX + ras_col] : '0;
        hazard_prefix[ras_row * MAP_MAX + ras_col] = above + CNTW'(row_run);
        ras_col++;
        if (ras_col >= w) begin
            ras_col = 0;
            row_run = 0;
            ras_row++;
            if (ras_row >= h) begin
                map_ready = 1'b1;
                maps_done++;
            end
        end
        return 1'b1;
    endfunction

    function automatic t_answer count_hazards_in(t_cmd c);
        t_answer     a;
        int unsigned w;
        int unsigned h;
        w = span(cfg_w);
        h = span(cfg_h);
        a.st = ST_NOT_READY;
        a.cnt = '0;
        if (!map_ready || w == 0 || h == 0)
            return a;
        if (c.lx > c.ux || c.ly > c.uy || c.ux >= w || c.uy >= h) begin
            a.st = ST_BAD_RECT;
            return a;
        end
        a.st = ST_OK;
        a.cnt = integral_at(c.ux + 1, c.uy + 1) - integral_at(c.lx, c.uy + 1)
              - integral_at(c.ux + 1, c.ly) + integral_at(c.lx, c.ly);
        return a;
    endfunction

    function automatic void apply_reg_write(bit [IDXW-1:0] idx, bit [SZW-1:0] val);
        case (idx)
            REG_MAP_WIDTH:        cfg_w = val;
            REG_MAP_HEIGHT:       cfg_h = val;
            REG_UNKNOWN_CODE:     cfg_unk = val[CW-1:0];
            REG_LETHAL_THRESHOLD: cfg_lethal = val[CW-1:0];
            default: ;
        endcase
        restart_raster();
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (gaps_off || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Costs lean toward hazards so that counts stay interesting.
    function automatic bit [CW-1:0] pick_cost();
        case ($urandom_range(0, 4))
            0:       return cfg_unk;
            1:       return CW'($urandom_range(cfg_lethal, 255));
            default: return CW'($urandom);
        endcase
    endfunction

    function automatic t_cmd rand_cmd(t_opcode op);
        t_cmd c;
        c.op = op;
        c.nm = 1'($urandom);
        c.cost = CW'($urandom);
        c.lx = CW'($urandom);
        c.ly = CW'($urandom);
        c.ux = CW'($urandom);
        c.uy = CW'($urandom);
        return c;
    endfunction

    // Mostly rectangles inside the map in use; the rest are arbitrary bounds.
    function automatic t_cmd shaped_query();
        t_cmd        c;
        int unsigned w;
        int unsigned h;
        c = rand_cmd(OP_QUERY);
        w = span(cfg_w);
        h = span(cfg_h);
        if (w == 0 || h == 0 || $urandom_range(0, 5) == 0)
            return c;
        c.lx = CW'($urandom_range(0, w - 1));
        c.ux = CW'($urandom_range(c.lx, w - 1));
        c.ly = CW'($urandom_range(0, h - 1));
        c.uy = CW'($urandom_range(c.ly, h - 1));
        if ($urandom_range(0, 9) == 0 && w < MAP_MAX)
            c.ux = CW'(w);
        return c;
    endfunction

    function automatic t_row cell_row(bit nm, bit [CW-1:0] cost);
        t_row r;
        r.kind = ROW_CMD;
        r.cmd = rand_cmd(OP_CELL);
        r.cmd.nm = nm;
        r.cmd.cost = cost;
        r.reg_idx = '0;
        r.reg_val = '0;
        r.typed = 1'b0;
        r.want = ST_OK;
        return r;
    endfunction

    function automatic t_row query_row(bit nm, bit [CW-1:0] lx, bit [CW-1:0] ly,
                                       bit [CW-1:0] ux, bit [CW-1:0] uy,
                                       bit typed, t_status want);
        t_row r;
        r.kind = ROW_CMD;
        r.cmd = rand_cmd(OP_QUERY);
        r.cmd.nm = nm;
        r.cmd.lx = lx;
        r.cmd.ly = ly;
        r.cmd.ux = ux;
        r.cmd.uy = uy;
        r.reg_idx = '0;
        r.reg_val = '0;
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    function automatic t_row reg_row(bit [IDXW-1:0] idx, bit [SZW-1:0] val);
        t_row r;
        r.kind = ROW_REG;
        r.cmd = rand_cmd(OP_CELL);
        r.reg_idx = idx;
        r.reg_val = val;
        r.typed = 1'b0;
        r.want = ST_OK;
        return r;
    endfunction

    function automatic void append_row(t_row r);
        plan = {plan, r};
    endfunction

    task automatic note_mismatch(string what);
        err_count++;
        if (err_count <= PRINT_CAP)
            $display("%0t ns: mismatch: %s", $realtime, what);
    endtask

    task automatic hold_off(int unsigned n);
        if (n == 0)
            return;
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Drives one transaction, waits for it to be taken and records what it must produce.
    task automatic issue(t_cmd c, bit typed, t_status want);
        t_answer a;
        hold_off(pick_gap());
        start <= 1'b1;
        i_opcode <= c.op;
        i_new_map <= c.nm;
        i_cell_cost <= c.cost;
        i_rect_min_x <= c.lx;
        i_rect_min_y <= c.ly;
        i_rect_max_x <= c.ux;
        i_rect_max_y <= c.uy;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (c.op == OP_CELL) begin
            if (integrate_cell(c.nm, c.cost))
                live_items++;
        end else begin
            a = count_hazards_in(c);
            if (typed) begin
                a.st = want;
                a.cnt = '0;
            end
            answers_due = {answers_due, a};
            live_items++;
            queries_sent++;
            if (a.st == ST_OK)
                ok_answers++;
        end
    endtask

    // Registers change only with the unit idle: every answer in and the queue drained.
    task automatic settle();
        start <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(bit [IDXW-1:0] idx, bit [SZW-1:0] val);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        apply_reg_write(idx, val);
        reg_writes++;
    endtask

    task automatic map_phase(bit fresh, bit [SZW-1:0] w_reg, bit [SZW-1:0] h_reg,
                             bit [SZW-1:0] unk_reg, bit [SZW-1:0] lethal_reg);
        int unsigned cells;
        int unsigned i;
        t_cmd        c;
        if (fresh) begin
            write_reg(REG_MAP_WIDTH, w_reg);
            write_reg(REG_MAP_HEIGHT, h_reg);
            write_reg(REG_UNKNOWN_CODE, unk_reg);
            write_reg(REG_LETHAL_THRESHOLD, lethal_reg);
        end
        cells = (span(cfg_w) == 0 || span(cfg_h) == 0) ? 3 : span(cfg_w) * span(cfg_h);
        i = 0;
        while (i < cells) begin
            if ($urandom_range(0, 29) == 0)
                issue(rand_cmd(OP_QUERY), 1'b0, ST_OK);
            c = rand_cmd(OP_CELL);
            c.cost = pick_cost();
            c.nm = (i == 0) ? (!fresh || 1'($urandom)) : 1'b0;
            // Now and then the map is abandoned and restarted from the origin.
            if (i > 0 && $urandom_range(0, 4 * cells) == 0) begin
                c.nm = 1'b1;
                i = 0;
            end
            issue(c, 1'b0, ST_OK);
            i++;
        end
        if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                c = rand_cmd(OP_CELL);
                c.nm = 1'b0;
                issue(c, 1'b0, ST_OK);
            end
        end
        repeat ($urandom_range(4, 14)) issue(shaped_query(), 1'b0, ST_OK);
        if ($urandom_range(0, 4) == 0) begin
            c = rand_cmd(OP_CELL);
            c.nm = 1'b1;
            issue(c, 1'b0, ST_OK);
            issue(shaped_query(), 1'b0, ST_OK);
        end
    endtask

    always @(posedge i_clk) begin
        t_answer a;
        if (i_rst_n && o_result_valid) begin
            if (answers_due.size() == 0) begin
                note_mismatch($sformatf("unexpected result, status %0d count %0d",
                                        o_query_status, o_hazard_count));
            end else begin
                a = answers_due.pop_front();
                if (o_query_status !== a.st)
                    note_mismatch($sformatf("status %0d, expected %0d",
                                            o_query_status, a.st));
                if (o_hazard_count !== a.cnt)
                    note_mismatch($sformatf("hazard count %0d, expected %0d",
                                            o_hazard_count, a.cnt));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_valid || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("tb_hazard_summed_area_table_unit: errors");
            $finish;
        end
    end

    initial begin
        int unsigned  r;
        bit [SZW-1:0] w_reg;
        bit [SZW-1:0] h_reg;
        bit [SZW-1:0] lethal_reg;

        // Right after reset the table holds nothing, whatever the bounds.
        append_row(query_row(1'b0, 0, 0, 0, 0, 1'b1, ST_NOT_READY));
        append_row(query_row(1'b1, 255, 255, 255, 255, 1'b1, ST_NOT_READY));
        append_row(reg_row(REG_MAP_WIDTH, 3));
        append_row(reg_row(REG_MAP_HEIGHT, 2));
        append_row(reg_row(REG_UNKNOWN_CODE, 9'h107));
        append_row(reg_row(REG_LETHAL_THRESHOLD, 200));
        // A 3x2 map: unknown code, at threshold, just below, top cost, zero, near unknown.
        append_row(cell_row(1'b1, 7));
        append_row(cell_row(1'b0, 200));
        append_row(cell_row(1'b0, 199));
        append_row(cell_row(1'b0, 255));
        append_row(cell_row(1'b0, 0));
        append_row(cell_row(1'b0, 6));
        append_row(cell_row(1'b0, 255));
        append_row(query_row(1'b0, 0, 0, 2, 1, 1'b0, ST_OK));
        append_row(query_row(1'b1, 1, 1, 1, 1, 1'b0, ST_OK));
        append_row(query_row(1'b0, 1, 0, 2, 1, 1'b0, ST_OK));
        append_row(query_row(1'b0, 2, 0, 1, 1, 1'b1, ST_BAD_RECT));
        append_row(query_row(1'b0, 0, 1, 2, 0, 1'b1, ST_BAD_RECT));
        append_row(query_row(1'b0, 0, 0, 3, 1, 1'b1, ST_BAD_RECT));
        append_row(query_row(1'b0, 0, 0, 2, 2, 1'b1, ST_BAD_RECT));
        append_row(cell_row(1'b1, 255));
        append_row(query_row(1'b0, 0, 0, 0, 0, 1'b1, ST_NOT_READY));
        append_row(reg_row(REG_MAP_WIDTH, 0));
        append_row(cell_row(1'b1, 255));
        // Zero size wins over inverted bounds.
        append_row(query_row(1'b0, 3, 0, 1, 0, 1'b1, ST_NOT_READY));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_REG)
                write_reg(plan[k].reg_idx, plan[k].reg_val);
            else
                issue(plan[k].cmd, plan[k].typed, plan[k].want);
        end

        // One small map streamed back to back keeps the queue full between cells.
        gaps_off = 1'b1;
        map_phase(1'b1, 12, 10, 0, 200);

        while (live_items < RANDOM_ITEMS) begin
            gaps_off = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 65) begin
                w_reg = SZW'($urandom_range(1, 8));
                h_reg = SZW'($urandom_range(1, 8));
            end else if (r < 75) begin
                w_reg = SZW'($urandom_range(9, 24));
                h_reg = SZW'($urandom_range(2, 12));
            end else if (r < 83) begin
                w_reg = SZW'($urandom_range(129, 511));
                h_reg = SZW'($urandom_range(1, 2));
            end else if (r < 91) begin
                w_reg = SZW'($urandom_range(1, 2));
                h_reg = SZW'($urandom_range(129, 511));
            end else begin
                w_reg = SZW'($urandom);
                h_reg = SZW'($urandom);
                if ($urandom_range(0, 1) == 0)
                    w_reg = '0;
                else
                    h_reg = '0;
            end
            r = $urandom_range(0, 9);
            if (r == 0)
                lethal_reg = '0;
            else if (r == 1)
                lethal_reg = 255;
            else
                lethal_reg = SZW'($urandom_range(120, 255));
            lethal_reg[CW] = 1'($urandom);
            map_phase($urandom_range(0, 2) != 0, w_reg, h_reg, SZW'($urandom), lethal_reg);
        end

        settle();
        $display("covered %0d register writes, %0d completed maps, %0d queries (%0d answered ok)",
                 reg_writes, maps_done, queries_sent, ok_answers);
        if (err_count == 0)
            $display("tb_hazard_summed_area_table_unit: clean");
        else
            $display("tb_hazard_summed_area_table_unit: errors");
        $finish;
    end

endmodule

>>> files.f
rtl/hsat_pkg.sv
rtl/hsat_front.sv
rtl/hsat_fifo.sv
rtl/hsat_back.sv
rtl/hazard_summed_area_table_unit.sv
sim/tb_hazard_summed_area_table_unit.sv
